// ===== rtl/misra_gries_heavy_hitters_assert.svh =====
// Assertion macros for the Misra-Gries heavy hitters block.
`ifndef MISRA_GRIES_HEAVY_HITTERS_ASSERT_SVH
`define MISRA_GRIES_HEAVY_HITTERS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MGH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MGH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mgh_pkg.sv =====
// Shared constants and types for the Misra-Gries heavy hitters block.
package mgh_pkg;

  localparam int SLOTS = 16;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int KEY_W = 32;
  localparam int COUNT_W = 32;
  localparam int IDX_W = 4;
  localparam int LIMIT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(SLOTS);

  typedef enum logic {
    CMD_FEED = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_INC  = 2'd0,
    OUT_INS  = 2'd1,
    OUT_DROP = 2'd2,
    OUT_READ = 2'd3
  } outcome_t;

  typedef struct packed {
    logic inc;
    logic ins;
    logic dec;
  } mgh_op_t;

endpackage

// ===== rtl/mgh_cell.sv =====
// One key/counter cell of the frequent-items row.
module mgh_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        capture,
  input  logic [mgh_pkg::KEY_W-1:0]   cmp_key,
  input  logic [mgh_pkg::KEY_W-1:0]   new_key,
  input  mgh_pkg::mgh_op_t            op,
  input  logic                        free_in,
  output logic                        free_out,
  output logic                        match,
  output logic                        one,
  output logic [mgh_pkg::KEY_W-1:0]   key,
  output logic [mgh_pkg::COUNT_W-1:0] count
);

  logic [mgh_pkg::KEY_W-1:0]   key_r;
  logic [mgh_pkg::KEY_W-1:0]   key_nxt;
  logic [mgh_pkg::COUNT_W-1:0] count_r;
  logic [mgh_pkg::COUNT_W-1:0] count_nxt;
  logic                        match_r;
  logic                        one_r;
  logic                        free_r;
  logic                        occ;
  logic                        ins_here;

  assign occ      = (count_r != '0);
  assign free_out = free_in | free_r;
  assign ins_here = op.ins & free_r & ~free_in;
  assign match    = match_r;
  assign one      = one_r;
  assign key      = key_r;
  assign count    = count_r;

  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    if (op.inc && match_r && (count_r != mgh_pkg::COUNT_MAX)) begin
      count_nxt = count_r + 1'b1;
    end
    if (ins_here) begin
      key_nxt   = new_key;
      count_nxt = mgh_pkg::COUNT_W'(1);
    end
    if (op.dec && occ) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      match_r <= 1'b0;
      one_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (capture) begin
        match_r <= occ && (key_r == cmp_key);
        one_r   <= (count_r == mgh_pkg::COUNT_W'(1));
        free_r  <= ~occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== rtl/misra_gries_heavy_hitters.sv =====
// Misra-Gries heavy hitters: a row of key/counter cells with a command port and an APB
// register. An item is accepted when start is high and busy is low; busy then stays high
// for one cycle, and the result strobe out_valid, registered from busy, is high for one
// cycle; no new item is accepted while busy is high. At the accept, every cell compares
// the key against its own and records free and count-of-one flags; while busy, the row
// applies increment, insert into the lowest free cell, or decrement-all. The receiver
// cannot stall: out_valid marks each result for exactly one cycle.
module misra_gries_heavy_hitters (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [mgh_pkg::KEY_W-1:0]   in_item_key,
  input  logic [mgh_pkg::IDX_W-1:0]   in_slot_index,
  output logic                        out_valid,
  output logic [1:0]                  out_outcome,
  output logic                        out_slot_valid,
  output logic [mgh_pkg::KEY_W-1:0]   out_slot_key,
  output logic [mgh_pkg::COUNT_W-1:0] out_slot_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic                               busy_r;
  logic                               cmd_r;
  logic [mgh_pkg::KEY_W-1:0]          key_r;
  logic [mgh_pkg::IDX_W-1:0]          idx_r;
  logic [mgh_pkg::LIMIT_W-1:0]        limit_r;
  logic [mgh_pkg::CNT_W-1:0]          used_r;
  logic [mgh_pkg::CNT_W-1:0]          used_nxt;
  logic [mgh_pkg::CNT_W-1:0]          n_ones;

  logic                               out_valid_r;
  logic [1:0]                         out_outcome_r;
  logic                               out_slot_valid_r;
  logic [mgh_pkg::KEY_W-1:0]          out_slot_key_r;
  logic [mgh_pkg::COUNT_W-1:0]        out_slot_count_r;

  logic                               accept;
  logic                               feed;
  logic                               any_match;
  logic                               room;
  mgh_pkg::mgh_op_t                   op;
  logic [mgh_pkg::SLOTS:0]            free_c;
  logic [mgh_pkg::SLOTS-1:0]          match_v;
  logic [mgh_pkg::SLOTS-1:0]          one_v;
  logic [mgh_pkg::KEY_W-1:0]          cell_key [mgh_pkg::SLOTS];
  logic [mgh_pkg::COUNT_W-1:0]        cell_count [mgh_pkg::SLOTS];
  logic [mgh_pkg::KEY_W-1:0]          rd_key;
  logic [mgh_pkg::COUNT_W-1:0]        rd_count;
  logic                               rd_valid;
  mgh_pkg::outcome_t                  outcome;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign free_c[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < mgh_pkg::SLOTS; g++) begin : g_cell
      mgh_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .capture  (accept),
        .cmp_key  (in_item_key),
        .new_key  (key_r),
        .op       (op),
        .free_in  (free_c[g]),
        .free_out (free_c[g+1]),
        .match    (match_v[g]),
        .one      (one_v[g]),
        .key      (cell_key[g]),
        .count    (cell_count[g])
      );
    end
  endgenerate

  assign feed      = busy_r && (cmd_r == mgh_pkg::CMD_FEED);
  assign any_match = |match_v;
  assign room      = (32'(used_r) < 32'(limit_r)) && (32'(used_r) < mgh_pkg::SLOTS)
                     && free_c[mgh_pkg::SLOTS];
  assign n_ones    = mgh_pkg::CNT_W'($countones(one_v));

  always_comb begin
    op.inc = feed && any_match;
    op.ins = feed && !any_match && room;
    op.dec = feed && !any_match && !room;
  end

  always_comb begin
    used_nxt = used_r;
    if (op.ins) begin
      used_nxt = used_r + 1'b1;
    end else if (op.dec) begin
      used_nxt = used_r - n_ones;
    end
  end

  always_comb begin
    rd_key   = '0;
    rd_count = '0;
    for (int i = 0; i < mgh_pkg::SLOTS; i++) begin
      if (32'(idx_r) == i) begin
        rd_key   = rd_key | cell_key[i];
        rd_count = rd_count | cell_count[i];
      end
    end
    rd_valid = (rd_count != '0);
  end

  always_comb begin
    if (cmd_r == mgh_pkg::CMD_READ) begin
      outcome = mgh_pkg::OUT_READ;
    end else if (any_match) begin
      outcome = mgh_pkg::OUT_INC;
    end else if (room) begin
      outcome = mgh_pkg::OUT_INS;
    end else begin
      outcome = mgh_pkg::OUT_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      limit_r     <= mgh_pkg::LIMIT_RESET;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      used_r      <= used_nxt;
      if (psel && penable && pwrite && !paddr[2]) begin
        limit_r <= pwdata[mgh_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      key_r <= in_item_key;
      idx_r <= in_slot_index;
    end
    if (busy_r) begin
      out_outcome_r <= outcome;
      if (cmd_r == mgh_pkg::CMD_READ && rd_valid) begin
        out_slot_valid_r <= 1'b1;
        out_slot_key_r   <= rd_key;
        out_slot_count_r <= rd_count;
      end else begin
        out_slot_valid_r <= 1'b0;
        out_slot_key_r   <= '0;
        out_slot_count_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = out_outcome_r;
  assign out_slot_valid = out_slot_valid_r;
  assign out_slot_key   = out_slot_key_r;
  assign out_slot_count = out_slot_count_r;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(limit_r);

endmodule

// ===== rtl/mgh_checker.sv =====
// Port-level checker for the Misra-Gries heavy hitters block, bound to the top level.
`include "misra_gries_heavy_hitters_assert.svh"

module mgh_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [1:0]                  out_outcome,
  input logic                        out_slot_valid,
  input logic [mgh_pkg::KEY_W-1:0]   out_slot_key,
  input logic [mgh_pkg::COUNT_W-1:0] out_slot_count
);

  `MGH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `MGH_ASSERT_NEXT(a_busy_result, busy, !busy && out_valid, "busy cycle not followed by result")
  `MGH_ASSERT_NOW(a_result_cause, out_valid, $past(busy), "result strobe without prior work")
  `MGH_ASSERT_NOW(a_feed_zero, out_valid && out_outcome != mgh_pkg::OUT_READ,
    !out_slot_valid && out_slot_key == '0 && out_slot_count == '0, "feed result carries slot data")
  `MGH_ASSERT_NOW(a_read_free, out_valid && out_outcome == mgh_pkg::OUT_READ && !out_slot_valid,
    out_slot_key == '0 && out_slot_count == '0, "free slot read shows data")

endmodule

bind misra_gries_heavy_hitters mgh_checker u_mgh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_outcome    (out_outcome),
  .out_slot_valid (out_slot_valid),
  .out_slot_key   (out_slot_key),
  .out_slot_count (out_slot_count)
);
